FILE: rtl/bptc_pkg.sv
// Package for the barometric pressure / temperature compensation block.
// Beat types, register indexes, status codes and pipeline stage map.
// No dependencies.
`default_nettype none

package bptc_pkg;

  // Input beat: one raw temperature and one raw pressure reading
  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
  } bptc_in_t;

  // Output beat: compensated values and status
  typedef struct packed {
    logic signed [15:0] temperature_deci_c;
    logic [19:0]        pressure_pa;
    logic [2:0]         status;
  } bptc_out_t;

  // Configuration register indexes
  localparam logic [2:0] REG_AC1  = 3'd0;
  localparam logic [2:0] REG_AC2  = 3'd1;
  localparam logic [2:0] REG_AC3  = 3'd2;
  localparam logic [2:0] REG_B1   = 3'd3;
  localparam logic [2:0] REG_B2   = 3'd4;
  localparam logic [2:0] REG_UCOF = 3'd5;
  localparam logic [2:0] REG_MCOF = 3'd6;
  localparam logic [2:0] REG_OSR  = 3'd7;

  localparam int CFG_W = 48;

  // Status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BADCAL = 3'd1;
  localparam logic [2:0] ST_ZDIV  = 3'd2;
  localparam logic [2:0] ST_PINV  = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  // Pipeline stage map
  localparam int STG_IN     = 0;   // capture, temperature offset
  localparam int STG_X1MUL  = 1;   // (UT - AC6) * AC5
  localparam int STG_DEN    = 2;   // X1, divisor, dividend
  localparam int STG_D1PREP = 3;   // magnitudes and sign
  localparam int D1_STEPS   = 27;  // one quotient bit per stage
  localparam int STG_D1     = STG_D1PREP + 1;
  localparam int STG_B5     = STG_D1 + D1_STEPS;
  localparam int STG_B6     = STG_B5 + 1;
  localparam int STG_MULA   = STG_B6 + 1;
  localparam int STG_SHA    = STG_MULA + 1;
  localparam int STG_MULB   = STG_SHA + 1;
  localparam int STG_X3     = STG_MULB + 1;
  localparam int STG_B3     = STG_X3 + 1;
  localparam int STG_B4MUL  = STG_B3 + 1;
  localparam int STG_B7     = STG_B4MUL + 1;
  localparam int STG_D2PREP = STG_B7 + 1;
  localparam int D2_STEPS   = 64;
  localparam int STG_D2     = STG_D2PREP + 1;
  localparam int STG_PQ     = STG_D2 + D2_STEPS;
  localparam int STG_PMULA  = STG_PQ + 1;
  localparam int STG_PMULB  = STG_PMULA + 1;
  localparam int STG_PA     = STG_PMULB + 1;
  localparam int NSTG       = STG_PA + 1;

endpackage

`default_nettype wire

FILE: rtl/baro_pressure_temp_compensation.sv
// Top level of the pressure / temperature compensation block.
// Fully pipelined datapath with two bit-per-stage dividers and a 2-beat output queue.
// Depends on bptc_pkg.
`default_nettype none

// Usage:
//   Input channel in_valid/in_ready/in_data carries one raw temperature and
//   one raw pressure reading per beat. Output channel out_valid/out_ready/
//   out_data returns exactly one beat per input beat, in order: temperature
//   in 0.1 degC, pressure in Pa and a status code.
//   Calibration words and the oversampling setting are written through
//   cfg_write/cfg_index/cfg_data while the block is idle.
//   Throughput: one beat per cycle while the output queue is not full. The
//   depth is set by the two dividers, one quotient bit per stage (27 stages
//   for the temperature term, 64 for pressure).
//   A 2-entry output queue sits behind the pipeline; in_ready comes from
//   its fill level only, so a beat is still taken while a result waits.
//   When the receiver stalls and the queue fills, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
//   Reset (rst, synchronous) clears all valid bits and the queue, and sets
//   the calibration words to zero and oversampling to 3.
module baro_pressure_temp_compensation
  import bptc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bptc_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bptc_out_t              out_data,
  input  wire logic              cfg_write,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  typedef struct packed {
    logic [15:0]        ut;
    logic [18:0]        up;
    logic               bad;
    logic signed [16:0] d;
    logic signed [33:0] prod;
    logic signed [18:0] x1t;
    logic signed [19:0] den;
    logic signed [26:0] num;
    logic               dneg;
    logic               dvz;
    logic [19:0]        rem1;
    logic [26:0]        nq1;
    logic [19:0]        dd1;
    logic signed [27:0] b5;
    logic signed [23:0] t;
    logic signed [27:0] b6;
    logic signed [55:0] sqp;
    logic signed [43:0] ac2b6;
    logic signed [43:0] ac3b6;
    logic signed [43:0] sq;
    logic signed [32:0] x2a;
    logic signed [30:0] x1c;
    logic signed [59:0] b2sq;
    logic signed [59:0] b1sq;
    logic signed [49:0] x3;
    logic signed [42:0] x3c;
    logic signed [52:0] b3;
    logic signed [43:0] x3p;
    logic [58:0]        b4p;
    logic               inv;
    logic signed [53:0] diff;
    logic [43:0]        b4;
    logic [63:0]        b7;
    logic               b7lo;
    logic [43:0]        rem2;
    logic [63:0]        nq2;
    logic               huge;
    logic [23:0]        q24;
    logic [31:0]        sq2;
    logic [36:0]        m7;
    logic [43:0]        m3;
    logic signed [21:0] x2p;
    logic signed [30:0] pa;
  } pipe_t;

  // Configuration registers
  logic signed [15:0] ac1, ac2, ac3, b1, b2;
  logic [47:0]        ucof, mcof;
  logic [1:0]         osr;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1  <= '0;
      ac2  <= '0;
      ac3  <= '0;
      b1   <= '0;
      b2   <= '0;
      ucof <= '0;
      mcof <= '0;
      osr  <= 2'd3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_AC1:  ac1  <= cfg_data[15:0];
        REG_AC2:  ac2  <= cfg_data[15:0];
        REG_AC3:  ac3  <= cfg_data[15:0];
        REG_B1:   b1   <= cfg_data[15:0];
        REG_B2:   b2   <= cfg_data[15:0];
        REG_UCOF: ucof <= cfg_data[47:0];
        REG_MCOF: mcof <= cfg_data[47:0];
        REG_OSR:  osr  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        ac4, ac5, ac6;
  logic signed [15:0] mb, mc, md;
  logic [15:0]        osr_k;

  assign ac4   = ucof[47:32];
  assign ac5   = ucof[31:16];
  assign ac6   = ucof[15:0];
  assign mb    = mcof[47:32];
  assign mc    = mcof[31:16];
  assign md    = mcof[15:0];
  assign osr_k = 16'(50000 >> osr);

  // Pipeline registers, one global enable
  pipe_t            st [NSTG];
  pipe_t            nx [NSTG];
  logic [NSTG-1:0]  vld;
  logic             en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= nx;
    end
  end

  // Per-stage next-value logic
  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    pipe_t pv;

    if (i == 0) begin : g_first
      always_comb begin
        pv    = '0;
        pv.ut = in_data.raw_temperature;
        pv.up = in_data.raw_pressure;
      end
    end else begin : g_rest
      assign pv = st[i-1];
    end

    always_comb begin
      logic signed [18:0] x1s;
      logic [20:0]        r1;
      logic [44:0]        r2;
      logic               qb;
      logic signed [27:0] qs;
      logic signed [27:0] x2s;
      logic signed [27:0] t28;
      logic signed [44:0] s45;
      logic signed [50:0] t1;
      logic signed [54:0] s55;
      logic [69:0]        m70;
      logic [63:0]        p64;
      logic [15:0]        xs;
      logic signed [37:0] n38;
      logic signed [29:0] s30;

      nx[i] = pv;
      x1s = '0; r1 = '0; r2 = '0; qb = 1'b0; qs = '0; x2s = '0; t28 = '0;
      s45 = '0; t1 = '0; s55 = '0; m70 = '0; p64 = '0; xs = '0; n38 = '0;
      s30 = '0;

      if (i == STG_IN) begin
        // temperature offset, calibration sanity
        nx[i].d   = $signed({1'b0, pv.ut}) - $signed({1'b0, ac6});
        nx[i].bad = (ac4 == '0) || (ac4 == 16'hFFFF) || (ac5 == '0) ||
                    (ac5 == 16'hFFFF) || (ac6 == '0) || (ac6 == 16'hFFFF) ||
                    ((ac1 == '0) && (ac2 == '0) && (ac3 == '0) && (b1 == '0) &&
                     (b2 == '0) && (mb == '0) && (mc == '0) && (md == '0));
      end else if (i == STG_X1MUL) begin
        nx[i].prod = pv.d * $signed({1'b0, ac5});
      end else if (i == STG_DEN) begin
        x1s          = $signed(pv.prod[33:15]);
        nx[i].x1t    = x1s;
        nx[i].den    = x1s + md;
        nx[i].num    = $signed({mc, 11'b0});
      end else if (i == STG_D1PREP) begin
        nx[i].dneg = pv.num[26] ^ pv.den[19];
        nx[i].dvz  = (pv.den == '0);
        nx[i].nq1  = pv.num[26] ? 27'(-pv.num) : pv.num;
        nx[i].dd1  = pv.den[19] ? 20'(-pv.den) : pv.den;
        nx[i].rem1 = '0;
      end else if (i >= STG_D1 && i < STG_D1 + D1_STEPS) begin
        // restoring division step, temperature term
        r1 = {pv.rem1, pv.nq1[26]};
        if (r1 >= {1'b0, pv.dd1}) begin
          r1 = r1 - {1'b0, pv.dd1};
          qb = 1'b1;
        end
        nx[i].rem1 = r1[19:0];
        nx[i].nq1  = {pv.nq1[25:0], qb};
      end else if (i == STG_B5) begin
        qs       = $signed({1'b0, pv.nq1});
        x2s      = pv.dneg ? -qs : qs;
        nx[i].b5 = pv.x1t + x2s;
      end else if (i == STG_B6) begin
        t28      = pv.b5 + 28'sd8;
        nx[i].t  = t28[27:4];
        nx[i].b6 = pv.b5 - 28'sd4000;
      end else if (i == STG_MULA) begin
        nx[i].sqp   = pv.b6 * pv.b6;
        nx[i].ac2b6 = ac2 * pv.b6;
        nx[i].ac3b6 = ac3 * pv.b6;
      end else if (i == STG_SHA) begin
        nx[i].sq  = pv.sqp[55:12];
        nx[i].x2a = pv.ac2b6[43:11];
        nx[i].x1c = pv.ac3b6[43:13];
      end else if (i == STG_MULB) begin
        nx[i].b2sq = b2 * pv.sq;
        nx[i].b1sq = b1 * pv.sq;
      end else if (i == STG_X3) begin
        nx[i].x3  = $signed(pv.b2sq[59:11]) + pv.x2a;
        s45       = pv.x1c + $signed(pv.b1sq[59:16]) + 45'sd2;
        nx[i].x3c = s45[44:2];
      end else if (i == STG_B3) begin
        t1        = $signed({ac1, 2'b00}) + pv.x3;
        s55       = (55'(t1) <<< osr) + 55'sd2;
        nx[i].b3  = s55[54:2];
        nx[i].x3p = pv.x3c + 44'sd32768;
      end else if (i == STG_B4MUL) begin
        nx[i].b4p  = ac4 * pv.x3p[42:0];
        nx[i].inv  = pv.x3p[43] || ($signed({1'b0, pv.up}) <= pv.b3);
        nx[i].diff = $signed({1'b0, pv.up}) - pv.b3;
      end else if (i == STG_B7) begin
        nx[i].b4  = pv.b4p[58:15];
        m70       = {16'b0, pv.diff} * {54'b0, osr_k};
        nx[i].b7  = m70[63:0];
        nx[i].inv = pv.inv || (pv.b4p[58:15] == '0);
      end else if (i == STG_D2PREP) begin
        nx[i].b7lo = (pv.b7[63:31] == '0);
        nx[i].nq2  = (pv.b7[63:31] == '0) ? {pv.b7[62:0], 1'b0} : pv.b7;
        nx[i].rem2 = '0;
      end else if (i >= STG_D2 && i < STG_D2 + D2_STEPS) begin
        // restoring division step, pressure
        r2 = {pv.rem2, pv.nq2[63]};
        if (r2 >= {1'b0, pv.b4}) begin
          r2 = r2 - {1'b0, pv.b4};
          qb = 1'b1;
        end
        nx[i].rem2 = r2[43:0];
        nx[i].nq2  = {pv.nq2[62:0], qb};
      end else if (i == STG_PQ) begin
        p64        = pv.b7lo ? pv.nq2 : {pv.nq2[62:0], 1'b0};
        nx[i].huge = |p64[63:24];
        nx[i].q24  = p64[23:0];
      end else if (i == STG_PMULA) begin
        xs         = pv.q24[23:8];
        nx[i].sq2  = xs * xs;
        nx[i].m7   = pv.q24 * 13'd7357;
      end else if (i == STG_PMULB) begin
        nx[i].m3  = pv.sq2 * 12'd3038;
        n38       = -$signed({1'b0, pv.m7});
        nx[i].x2p = n38[37:16];
      end else if (i == STG_PA) begin
        s30      = $signed({2'b0, pv.m3[43:16]}) + pv.x2p + 30'sd3791;
        nx[i].pa = $signed({7'b0, pv.q24}) + $signed(s30[29:4]);
      end
    end
  end

  // Status and saturation on the last stage
  bptc_out_t fin;
  pipe_t     lst;

  assign lst = st[NSTG-1];

  always_comb begin
    logic signed [15:0] tsat;
    logic               oor;

    if (lst.t > 24'sd32767) begin
      tsat = 16'sd32767;
    end else if (lst.t < -24'sd32768) begin
      tsat = -16'sd32768;
    end else begin
      tsat = lst.t[15:0];
    end
    oor = lst.huge || (lst.pa < 31'sd25000) || (lst.pa > 31'sd125000) ||
          (lst.t < -24'sd600) || (lst.t > 24'sd850);

    fin = '0;
    if (lst.bad) begin
      fin.status = ST_BADCAL;
    end else if (lst.dvz) begin
      fin.status = ST_ZDIV;
    end else if (lst.inv) begin
      fin.status             = ST_PINV;
      fin.temperature_deci_c = tsat;
    end else begin
      fin.status             = oor ? ST_RANGE : ST_OK;
      fin.temperature_deci_c = tsat;
      if (lst.huge || lst.pa > 31'sd1048575) begin
        fin.pressure_pa = 20'hFFFFF;
      end else if (lst.pa < 31'sd0) begin
        fin.pressure_pa = '0;
      end else begin
        fin.pressure_pa = lst.pa[19:0];
      end
    end
  end

  // Two-entry output queue
  bptc_out_t  qmem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] cnt;
  logic       push, pop;

  assign en        = (cnt != 2'd2);
  assign in_ready  = en;
  assign push      = en && vld[NSTG-1];
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = qmem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= fin;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bptc_checker.sv
// Port-level checker for the compensation block, bound to the top level.
// Depends on bptc_pkg and baro_pressure_temp_compensation.
`default_nettype none

module bptc_checker
  import bptc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire bptc_out_t out_data
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // bad calibration zeroes both values
  a_badcal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_BADCAL |->
      out_data.temperature_deci_c == 16'sd0 && out_data.pressure_pa == 20'd0)
    else $error("bad calibration beat carries values");

  // zero divisor zeroes both values
  a_zdiv: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_ZDIV |->
      out_data.temperature_deci_c == 16'sd0 && out_data.pressure_pa == 20'd0)
    else $error("zero divisor beat carries values");

  // invalid pressure gives zero pressure
  a_pinv: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_PINV |-> out_data.pressure_pa == 20'd0)
    else $error("invalid pressure beat carries pressure");

  // ok beats lie inside the plausible window
  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_OK |->
      out_data.pressure_pa >= 20'd25000 && out_data.pressure_pa <= 20'd125000 &&
      out_data.temperature_deci_c >= -16'sd600 &&
      out_data.temperature_deci_c <= 16'sd850)
    else $error("ok beat outside range");

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
